[design/cnsg_pkg.sv]
// Shared types, constants and codes of the cell neighbour stencil generator.
package cnsg_pkg;

  // Grid and list bounds.
  localparam int GRID_MAX = 32;
  localparam int LIST_MAX = 64;

  // Field widths.
  localparam int COORD_W = 5;
  localparam int SIDE_W  = 6;
  localparam int DIST_W  = 12;
  localparam int LIMIT_W = 7;
  localparam int CELL_W  = 15;
  localparam int STAT_W  = 3;

  // Configuration port geometry.
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;

  // Register indexes.
  localparam logic [REG_IDX_W-1:0] REG_GRID_SIDE  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_D      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MAX_D2     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MAX_D3     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LIST_LIMIT = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_INNER_EN   = 3'd5;

  // Register reset values.
  localparam logic [SIDE_W-1:0]  RST_GRID_SIDE  = 6'd8;
  localparam logic [DIST_W-1:0]  RST_MAX_D      = 12'd1;
  localparam logic [DIST_W-1:0]  RST_MAX_D2     = 12'd1;
  localparam logic [DIST_W-1:0]  RST_MAX_D3     = 12'd1;
  localparam logic [LIMIT_W-1:0] RST_LIST_LIMIT = 7'd64;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_ENTRY    = 3'd0;
  localparam logic [STAT_W-1:0] ST_END      = 3'd1;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 3'd2;
  localparam logic [STAT_W-1:0] ST_BAD_THR  = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD_CELL = 3'd4;

  // Configuration register set.
  typedef struct packed {
    logic [SIDE_W-1:0]  grid_side;
    logic [DIST_W-1:0]  max_d;
    logic [DIST_W-1:0]  max_d2;
    logic [DIST_W-1:0]  max_d3;
    logic [LIMIT_W-1:0] list_limit;
    logic               inner_en;
  } cfg_t;

  // Verdict of the distance unit for one candidate cell.
  typedef struct packed {
    logic incl;
    logic f2;
    logic f3;
    logic n1;
    logic n2;
    logic n3;
  } dist_flags_t;

  // One result item as held in the output register.
  typedef struct packed {
    logic [CELL_W-1:0] nb_cell;
    logic              f2;
    logic              f3;
    logic              n1;
    logic              n2;
    logic              n3;
    logic [STAT_W-1:0] status;
    logic              last;
  } out_item_t;

endpackage

[design/cnsg_in_if.sv]
// Request channel carrying one centre cell per transaction.
interface cnsg_in_if;
  logic                        valid;
  logic                        ready;
  logic [cnsg_pkg::COORD_W-1:0] cell_x;
  logic [cnsg_pkg::COORD_W-1:0] cell_y;
  logic [cnsg_pkg::COORD_W-1:0] cell_z;

  modport source (output valid, output cell_x, output cell_y, output cell_z, input ready);
  modport sink   (input valid, input cell_x, input cell_y, input cell_z, output ready);
endinterface

[design/cnsg_out_if.sv]
// Result channel carrying one list entry or closing result per transaction.
interface cnsg_out_if;
  logic                        valid;
  logic                        ready;
  logic [cnsg_pkg::CELL_W-1:0] neighbor_cell;
  logic                        include_2;
  logic                        include_3;
  logic                        no_check;
  logic                        no_check_2;
  logic                        no_check_3;
  logic [cnsg_pkg::STAT_W-1:0] status;
  logic                        last;

  modport source (output valid, output neighbor_cell, output include_2, output include_3,
                  output no_check, output no_check_2, output no_check_3, output status,
                  output last, input ready);
  modport sink   (input valid, input neighbor_cell, input include_2, input include_3,
                  input no_check, input no_check_2, input no_check_3, input status,
                  input last, output ready);
endinterface

[design/cnsg_cfg_regs.sv]
// Configuration register file behind the APB-style port.
module cnsg_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cnsg_pkg::ADDR_W-1:0]   paddr,
  input  logic [cnsg_pkg::DATA_W-1:0]   pwdata,
  output logic [cnsg_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output cnsg_pkg::cfg_t                cfg
);

  cnsg_pkg::cfg_t                   cfg_r;
  cnsg_pkg::cfg_t                   cfg_nxt;
  logic [cnsg_pkg::REG_IDX_W-1:0]   reg_idx;
  logic                             wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[cnsg_pkg::ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  // Decode a write into the addressed register; unknown addresses are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        cnsg_pkg::REG_GRID_SIDE:  cfg_nxt.grid_side  = pwdata[cnsg_pkg::SIDE_W-1:0];
        cnsg_pkg::REG_MAX_D:      cfg_nxt.max_d      = pwdata[cnsg_pkg::DIST_W-1:0];
        cnsg_pkg::REG_MAX_D2:     cfg_nxt.max_d2     = pwdata[cnsg_pkg::DIST_W-1:0];
        cnsg_pkg::REG_MAX_D3:     cfg_nxt.max_d3     = pwdata[cnsg_pkg::DIST_W-1:0];
        cnsg_pkg::REG_LIST_LIMIT: cfg_nxt.list_limit = pwdata[cnsg_pkg::LIMIT_W-1:0];
        cnsg_pkg::REG_INNER_EN:   cfg_nxt.inner_en   = pwdata[0];
        default: ;
      endcase
    end
  end

  // Read-back of the addressed register, zero-extended.
  always_comb begin
    unique case (reg_idx)
      cnsg_pkg::REG_GRID_SIDE:  prdata = {{(cnsg_pkg::DATA_W-cnsg_pkg::SIDE_W){1'b0}},
                                          cfg_r.grid_side};
      cnsg_pkg::REG_MAX_D:      prdata = {{(cnsg_pkg::DATA_W-cnsg_pkg::DIST_W){1'b0}},
                                          cfg_r.max_d};
      cnsg_pkg::REG_MAX_D2:     prdata = {{(cnsg_pkg::DATA_W-cnsg_pkg::DIST_W){1'b0}},
                                          cfg_r.max_d2};
      cnsg_pkg::REG_MAX_D3:     prdata = {{(cnsg_pkg::DATA_W-cnsg_pkg::DIST_W){1'b0}},
                                          cfg_r.max_d3};
      cnsg_pkg::REG_LIST_LIMIT: prdata = {{(cnsg_pkg::DATA_W-cnsg_pkg::LIMIT_W){1'b0}},
                                          cfg_r.list_limit};
      cnsg_pkg::REG_INNER_EN:   prdata = {{(cnsg_pkg::DATA_W-1){1'b0}}, cfg_r.inner_en};
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_side  <= cnsg_pkg::RST_GRID_SIDE;
      cfg_r.max_d      <= cnsg_pkg::RST_MAX_D;
      cfg_r.max_d2     <= cnsg_pkg::RST_MAX_D2;
      cfg_r.max_d3     <= cnsg_pkg::RST_MAX_D3;
      cfg_r.list_limit <= cnsg_pkg::RST_LIST_LIMIT;
      cfg_r.inner_en   <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[design/cnsg_dist_unit.sv]
// Shared distance unit: evaluates one candidate cell against the thresholds.
module cnsg_dist_unit (
  input  logic [cnsg_pkg::COORD_W-1:0] cx,
  input  logic [cnsg_pkg::COORD_W-1:0] cy,
  input  logic [cnsg_pkg::COORD_W-1:0] cz,
  input  logic [cnsg_pkg::COORD_W-1:0] x,
  input  logic [cnsg_pkg::COORD_W-1:0] y,
  input  logic [cnsg_pkg::COORD_W-1:0] z,
  input  cnsg_pkg::cfg_t               cfg,
  output cnsg_pkg::dist_flags_t        flags
);

  localparam int LT_W = 2 * cnsg_pkg::COORD_W;
  localparam int GT_W = 2 * (cnsg_pkg::COORD_W + 1);

  function automatic logic [cnsg_pkg::COORD_W-1:0] abs_diff(
    input logic [cnsg_pkg::COORD_W-1:0] a,
    input logic [cnsg_pkg::COORD_W-1:0] b
  );
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Squared gap of an axis: zero when equal, else (d-1)^2.
  function automatic logic [LT_W-1:0] least_term(input logic [cnsg_pkg::COORD_W-1:0] d);
    logic [cnsg_pkg::COORD_W-1:0] g;
    g = d - 1'b1;
    return (d == '0) ? '0 : (LT_W'(g) * LT_W'(g));
  endfunction

  // Squared far reach of an axis: one when equal, else (d+1)^2.
  function automatic logic [GT_W-1:0] great_term(input logic [cnsg_pkg::COORD_W-1:0] d);
    logic [cnsg_pkg::COORD_W:0] g;
    g = {1'b0, d} + 1'b1;
    return (d == '0) ? GT_W'(1) : (GT_W'(g) * GT_W'(g));
  endfunction

  logic [cnsg_pkg::COORD_W-1:0] dx, dy, dz;
  logic [cnsg_pkg::DIST_W-1:0]  lo, hi;
  logic                         n1;
  logic                         n2;

  assign dx = abs_diff(x, cx);
  assign dy = abs_diff(y, cy);
  assign dz = abs_diff(z, cz);

  // Least and greatest squared cell distances.
  assign lo = cnsg_pkg::DIST_W'(least_term(dx)) + cnsg_pkg::DIST_W'(least_term(dy))
            + cnsg_pkg::DIST_W'(least_term(dz));
  assign hi = cnsg_pkg::DIST_W'(great_term(dx)) + cnsg_pkg::DIST_W'(great_term(dy))
            + cnsg_pkg::DIST_W'(great_term(dz));

  // Threshold flags; the inner ones chain through the three thresholds.
  assign n1 = cfg.inner_en && (hi < cfg.max_d);
  assign n2 = n1 && (hi < cfg.max_d2);

  assign flags.incl = lo < cfg.max_d;
  assign flags.f2   = lo < cfg.max_d2;
  assign flags.f3   = (lo < cfg.max_d2) && (lo < cfg.max_d3);
  assign flags.n1   = n1;
  assign flags.n2   = n2;
  assign flags.n3   = n2 && (hi < cfg.max_d3);

endmodule

[design/cell_neighbor_stencil_generator.sv]
// Top level: request checks, scan sequencer around the distance unit, output register.
// A rejected request (bad thresholds or bad cell) gives its single result in the cycle
// after acceptance. An accepted scan visits one candidate cell per cycle through the
// distance unit, holding while an included cell waits on the output register, over side
// cubed cells (grid_side capped at 32) or up to a list overflow, then gives a closing result.
// A new request is taken once the scan has ended and the output register can load.
// Reset is synchronous and active low; it clears the sequencer and the output valid.
module cell_neighbor_stencil_generator (
  input  logic                          clk,
  input  logic                          rst_n,
  cnsg_in_if.sink                       in_chan,
  cnsg_out_if.source                    out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cnsg_pkg::ADDR_W-1:0]   paddr,
  input  logic [cnsg_pkg::DATA_W-1:0]   pwdata,
  output logic [cnsg_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_END  = 2'd2;

  cnsg_pkg::cfg_t         cfg;
  cnsg_pkg::dist_flags_t  flags;

  logic [1:0]                    state_r, state_nxt;
  logic [cnsg_pkg::COORD_W-1:0]  cx_r, cy_r, cz_r, cx_nxt, cy_nxt, cz_nxt;
  logic [cnsg_pkg::COORD_W-1:0]  x_r, y_r, z_r, x_nxt, y_nxt, z_nxt;
  logic [cnsg_pkg::CELL_W-1:0]   cell_r, cell_nxt;
  logic [cnsg_pkg::LIMIT_W-1:0]  count_r, count_nxt;
  logic                          ov_r, ov_nxt;
  cnsg_pkg::out_item_t           item_r, item_nxt;

  logic [cnsg_pkg::SIDE_W-1:0]   side_eff, side_m1;
  logic [cnsg_pkg::LIMIT_W-1:0]  limit_eff;
  logic                          bad_thr, bad_cell, can_load, in_acc, overflow;
  logic                          z_end, y_end, x_end;

  cnsg_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cnsg_dist_unit u_dist (
    .cx    (cx_r),
    .cy    (cy_r),
    .cz    (cz_r),
    .x     (x_r),
    .y     (y_r),
    .z     (z_r),
    .cfg   (cfg),
    .flags (flags)
  );

  // Effective side and list limit after saturation.
  assign side_eff  = (cfg.grid_side > cnsg_pkg::SIDE_W'(cnsg_pkg::GRID_MAX))
                   ? cnsg_pkg::SIDE_W'(cnsg_pkg::GRID_MAX) : cfg.grid_side;
  assign side_m1   = side_eff - 1'b1;
  assign limit_eff = (cfg.list_limit == '0) ? cnsg_pkg::LIMIT_W'(1)
                   : (cfg.list_limit > cnsg_pkg::LIMIT_W'(cnsg_pkg::LIST_MAX))
                   ? cnsg_pkg::LIMIT_W'(cnsg_pkg::LIST_MAX) : cfg.list_limit;

  // Request checks.
  assign bad_thr  = (cfg.max_d2 > cfg.max_d) || (cfg.max_d3 > cfg.max_d2);
  assign bad_cell = ({1'b0, in_chan.cell_x} >= side_eff) || ({1'b0, in_chan.cell_y} >= side_eff)
                 || ({1'b0, in_chan.cell_z} >= side_eff);

  // Handshake on both sides.
  assign can_load      = !ov_r || out_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE) && can_load;
  assign in_acc        = in_chan.valid && in_chan.ready;

  // Scan position and list length.
  assign z_end    = {1'b0, z_r} == side_m1;
  assign y_end    = {1'b0, y_r} == side_m1;
  assign x_end    = {1'b0, x_r} == side_m1;
  assign overflow = ({1'b0, count_r} + 1'b1) >= {1'b0, limit_eff};

  // Sequencer and output register loading.
  always_comb begin
    state_nxt = state_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    cz_nxt    = cz_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    cell_nxt  = cell_r;
    count_nxt = count_r;
    ov_nxt    = ov_r && !out_chan.ready;
    item_nxt  = item_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (bad_thr || bad_cell) begin
            ov_nxt        = 1'b1;
            item_nxt      = '0;
            item_nxt.status = bad_thr ? cnsg_pkg::ST_BAD_THR : cnsg_pkg::ST_BAD_CELL;
            item_nxt.last = 1'b1;
          end else begin
            cx_nxt    = in_chan.cell_x;
            cy_nxt    = in_chan.cell_y;
            cz_nxt    = in_chan.cell_z;
            x_nxt     = '0;
            y_nxt     = '0;
            z_nxt     = '0;
            cell_nxt  = '0;
            count_nxt = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (!flags.incl || can_load) begin
          if (flags.incl && overflow) begin
            ov_nxt          = 1'b1;
            item_nxt        = '0;
            item_nxt.status = cnsg_pkg::ST_OVERFLOW;
            item_nxt.last   = 1'b1;
            state_nxt       = S_IDLE;
          end else begin
            if (flags.incl) begin
              ov_nxt           = 1'b1;
              item_nxt.nb_cell = cell_r;
              item_nxt.f2      = flags.f2;
              item_nxt.f3      = flags.f3;
              item_nxt.n1      = flags.n1;
              item_nxt.n2      = flags.n2;
              item_nxt.n3      = flags.n3;
              item_nxt.status  = cnsg_pkg::ST_ENTRY;
              item_nxt.last    = 1'b0;
              count_nxt        = count_r + 1'b1;
            end
            // Step to the next candidate in linear order.
            cell_nxt = cell_r + 1'b1;
            if (z_end) begin
              z_nxt = '0;
              if (y_end) begin
                y_nxt = '0;
                if (x_end) begin
                  state_nxt = S_END;
                end else begin
                  x_nxt = x_r + 1'b1;
                end
              end else begin
                y_nxt = y_r + 1'b1;
              end
            end else begin
              z_nxt = z_r + 1'b1;
            end
          end
        end
      end
      S_END: begin
        if (can_load) begin
          ov_nxt          = 1'b1;
          item_nxt        = '0;
          item_nxt.status = cnsg_pkg::ST_END;
          item_nxt.last   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      count_r <= count_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    cz_r   <= cz_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    cell_r <= cell_nxt;
    item_r <= item_nxt;
  end

  // Result channel drive.
  assign out_chan.valid         = ov_r;
  assign out_chan.neighbor_cell = item_r.nb_cell;
  assign out_chan.include_2     = item_r.f2;
  assign out_chan.include_3     = item_r.f3;
  assign out_chan.no_check      = item_r.n1;
  assign out_chan.no_check_2    = item_r.n2;
  assign out_chan.no_check_3    = item_r.n3;
  assign out_chan.status        = item_r.status;
  assign out_chan.last          = item_r.last;

endmodule

[design/cnsg_checker.sv]
// Port-level checks of the stencil generator, bound to its top level.
module cnsg_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [cnsg_pkg::CELL_W-1:0]   out_cell,
  input logic                          out_inc2,
  input logic [cnsg_pkg::STAT_W-1:0]   out_status,
  input logic                          out_last
);

  // Only list entries leave the transaction open; every other result closes it.
  a_last_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_status != cnsg_pkg::ST_ENTRY)))
    else $error("last flag disagrees with status");

  // Status codes stay within the defined set.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= cnsg_pkg::ST_BAD_CELL))
    else $error("undefined status code");

  // Closing and error results carry a cleared neighbour cell and include_2 flag.
  a_close_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != cnsg_pkg::ST_ENTRY) |-> (out_cell == '0 && !out_inc2))
    else $error("closing result with non-zero payload");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status) && $stable(out_cell)))
    else $error("stalled result changed");

endmodule

bind cell_neighbor_stencil_generator cnsg_checker u_cnsg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_cell   (out_chan.neighbor_cell),
  .out_inc2   (out_chan.include_2),
  .out_status (out_chan.status),
  .out_last   (out_chan.last)
);
